[rtl/core/hbac_pkg.sv]
// ----------------------------------------------------------------------------
// hbac_pkg
// Shared types, constants and byte-scan functions for the Authorization
// header checker.
// ----------------------------------------------------------------------------
package hbac_pkg;

  localparam int MAX_CRED_BYTES = 32;
  localparam int CRED_BITS      = MAX_CRED_BYTES * 8;
  localparam int CRED_IDX_W     = $clog2(MAX_CRED_BYTES);
  localparam int WORD_BITS      = 64;

  localparam logic [3:0] AUTH_LEN     = 4'd13;
  localparam logic [5:0] CRED_LEN_RST = 6'd28;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CFG_CRED_LEN = 3'd0,
    CFG_WORD_0   = 3'd1,
    CFG_WORD_1   = 3'd2,
    CFG_WORD_2   = 3'd3,
    CFG_WORD_3   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_NAME   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SCHEME = 3'd2,
    PH_MID    = 3'd3,
    PH_CRED   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] name_idx;
    logic       name_ok;
    logic       line_empty;
    logic [5:0] cred_idx;
    logic       cred_ok;
  } line_t;

  typedef struct packed {
    logic valid;
    logic authorized;
    logic header_seen;
  } result_t;

  localparam line_t LINE_CLR = '{
    phase: PH_NAME, name_idx: 4'd0, name_ok: 1'b1,
    line_empty: 1'b1, cred_idx: 6'd0, cred_ok: 1'b1
  };

  function automatic logic [7:0] auth_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "A";
      4'd1:    c = "u";
      4'd2:    c = "t";
      4'd3:    c = "h";
      4'd4:    c = "o";
      4'd5:    c = "r";
      4'd6:    c = "i";
      4'd7:    c = "z";
      4'd8:    c = "a";
      4'd9:    c = "t";
      4'd10:   c = "i";
      4'd11:   c = "o";
      4'd12:   c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic line_t cred_step(input line_t s, input logic [7:0] b,
                                      input logic [5:0] len,
                                      input logic [CRED_BITS-1:0] cred);
    line_t      r;
    logic [7:0] exp_b;
    r     = s;
    exp_b = cred[{s.cred_idx[CRED_IDX_W-1:0], 3'b000} +: 8];
    if (s.cred_ok) begin
      if (s.cred_idx < len && s.cred_idx < 6'(MAX_CRED_BYTES) && b == exp_b) begin
        r.cred_idx = s.cred_idx + 6'd1;
      end else begin
        r.cred_ok = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic line_t feed(input line_t s, input logic [7:0] b,
                                 input logic [5:0] len,
                                 input logic [CRED_BITS-1:0] cred);
    line_t r;
    r = s;
    r.line_empty = 1'b0;
    unique case (s.phase)
      PH_NAME: begin
        if (b == CH_COLON) begin
          r.phase = PH_LEAD;
        end else if (s.name_ok && s.name_idx < AUTH_LEN && b == auth_char(s.name_idx)) begin
          r.name_idx = s.name_idx + 4'd1;
        end else begin
          r.name_ok = 1'b0;
        end
      end
      PH_LEAD: begin
        if (b != CH_SPACE) r.phase = PH_SCHEME;
      end
      PH_SCHEME: begin
        if (b == CH_SPACE) r.phase = PH_MID;
      end
      PH_MID: begin
        if (b != CH_SPACE) begin
          r = cred_step(r, b, len, cred);
          r.phase = PH_CRED;
        end
      end
      default: r = cred_step(r, b, len, cred);
    endcase
    return r;
  endfunction

endpackage

[rtl/core/http_basic_auth_header_check.sv]
// ----------------------------------------------------------------------------
// http_basic_auth_header_check
// Path: an accepted word waits in the input register, and its verdict is then
// registered in the output register, from which it leaves.
// Throughput: one word per cycle; the input register and the verdict
// register hold only while the output is stalled.
// Reset: synchronous, active low; scan state starts as a fresh connection,
// credential length 28 and credential bytes zero.
// ----------------------------------------------------------------------------
module http_basic_auth_header_check
  import hbac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_authorized,
  output logic                 out_header_seen,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  logic [5:0]           cred_len;
  logic [CRED_BITS-1:0] cred;
  logic                 res_room;
  result_t              res;

  assign cfg_ready = 1'b1;

  hbac_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cred_len (cred_len),
    .cred     (cred)
  );

  hbac_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .cred_len     (cred_len),
    .cred         (cred),
    .res_room     (res_room),
    .res          (res)
  );

  hbac_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .res_room        (res_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_authorized  (out_authorized),
    .out_header_seen (out_header_seen)
  );

endmodule

[rtl/core/hbac_cfg.sv]
// ----------------------------------------------------------------------------
// hbac_cfg
// Credential length and credential word registers.
// ----------------------------------------------------------------------------
module hbac_cfg
  import hbac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [5:0]           cred_len,
  output logic [CRED_BITS-1:0] cred
);

  logic [5:0]           cred_len_r;
  logic [CRED_BITS-1:0] cred_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_len_r <= CRED_LEN_RST;
      cred_r     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CRED_LEN: cred_len_r <= wr_data[5:0];
        CFG_WORD_0:   cred_r[0*WORD_BITS +: WORD_BITS] <= wr_data;
        CFG_WORD_1:   cred_r[1*WORD_BITS +: WORD_BITS] <= wr_data;
        CFG_WORD_2:   cred_r[2*WORD_BITS +: WORD_BITS] <= wr_data;
        CFG_WORD_3:   cred_r[3*WORD_BITS +: WORD_BITS] <= wr_data;
        default:      ;
      endcase
    end
  end

  assign cred_len = cred_len_r;
  assign cred     = cred_r;

endmodule

[rtl/core/hbac_scan.sv]
// ----------------------------------------------------------------------------
// hbac_scan
// Input word register and per-connection scan state; one word per cycle while the verdict register has room.
// ----------------------------------------------------------------------------
module hbac_scan
  import hbac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_data_byte,
  input  logic [5:0]           cred_len,
  input  logic [CRED_BITS-1:0] cred,
  input  logic                 res_room,
  output result_t              res
);

  logic       stg_valid_r, stg_valid_nxt;
  logic [1:0] stg_op_r;
  logic [7:0] stg_byte_r;
  logic       go;

  line_t line_r, line_nxt;
  logic  cr_pend_r, cr_pend_nxt;
  logic  hdr_r, hdr_nxt;
  logic  vok_r, vok_nxt;
  logic  fin_r, fin_nxt;
  line_t lt;

  assign go            = stg_valid_r && res_room;
  assign in_stall      = stg_valid_r && !res_room;
  assign stg_valid_nxt = in_valid || (stg_valid_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_op_r   <= in_op;
      stg_byte_r <= in_data_byte;
    end
  end

  always_comb begin
    line_nxt    = line_r;
    cr_pend_nxt = cr_pend_r;
    hdr_nxt     = hdr_r;
    vok_nxt     = vok_r;
    fin_nxt     = fin_r;
    res         = '0;
    lt          = line_r;
    if (go) begin
      unique case (stg_op_r)
        OP_START: begin
          line_nxt    = LINE_CLR;
          cr_pend_nxt = 1'b0;
          hdr_nxt     = 1'b0;
          vok_nxt     = 1'b0;
          fin_nxt     = 1'b0;
        end
        OP_CLOSE: begin
          if (!fin_r) begin
            fin_nxt         = 1'b1;
            res.valid       = 1'b1;
            res.authorized  = hdr_r && vok_r;
            res.header_seen = hdr_r;
          end
        end
        OP_DATA: begin
          if (!fin_r) begin
            if (cr_pend_r && stg_byte_r == CH_LF) begin
              cr_pend_nxt = 1'b0;
              if (line_r.line_empty) begin
                fin_nxt         = 1'b1;
                res.valid       = 1'b1;
                res.authorized  = hdr_r && vok_r;
                res.header_seen = hdr_r;
              end else begin
                if (!hdr_r && line_r.name_ok && line_r.name_idx == AUTH_LEN) begin
                  hdr_nxt = 1'b1;
                  vok_nxt = line_r.cred_ok && line_r.cred_idx == cred_len;
                end
                line_nxt = LINE_CLR;
              end
            end else begin
              // a CR not followed by LF is plain data
              if (cr_pend_r) lt = feed(line_r, CH_CR, cred_len, cred);
              if (stg_byte_r == CH_CR) begin
                cr_pend_nxt = 1'b1;
                line_nxt    = lt;
              end else begin
                cr_pend_nxt = 1'b0;
                line_nxt    = feed(lt, stg_byte_r, cred_len, cred);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r    <= LINE_CLR;
      cr_pend_r <= 1'b0;
      hdr_r     <= 1'b0;
      vok_r     <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      line_r    <= line_nxt;
      cr_pend_r <= cr_pend_nxt;
      hdr_r     <= hdr_nxt;
      vok_r     <= vok_nxt;
      fin_r     <= fin_nxt;
    end
  end

endmodule

[rtl/core/hbac_out.sv]
// ----------------------------------------------------------------------------
// hbac_out
// Verdict output register.
// ----------------------------------------------------------------------------
module hbac_out
  import hbac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  result_t res,
  output logic    res_room,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    out_authorized,
  output logic    out_header_seen
);

  logic out_valid_r, out_valid_nxt;
  logic auth_r;
  logic seen_r;

  assign res_room      = !out_valid_r || !out_stall;
  assign out_valid_nxt = res.valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      auth_r <= res.authorized;
      seen_r <= res.header_seen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_authorized  = auth_r;
  assign out_header_seen = seen_r;

endmodule

[tb/tb_http_basic_auth_header_check.sv]
// ----------------------------------------------------------------------------
// tb_http_basic_auth_header_check
// Drives header byte streams with random gaps and output stalls, tracks the
// expected verdict of each connection in a scoreboard and checks every
// verdict word field by field, across several credential settings.
// ----------------------------------------------------------------------------
module tb_http_basic_auth_header_check;
  timeunit 1ns;
  timeprecision 1ps;
  import hbac_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         ITEM_TARGET    = 400;
  localparam int         LONG_HOLD      = 80;
  localparam int         WATCHDOG_LIMIT = 2000;

  class verdict_tracker;
    typedef struct packed {
      logic authorized;
      logic header_seen;
    } verdict_t;

    logic [5:0]           cred_len;
    logic [CRED_BITS-1:0] cred_bytes;
    logic [103:0]         auth_text;
    phase_t               phase;
    logic [3:0]           name_pos;
    logic [5:0]           cred_pos;
    bit                   name_ok;
    bit                   line_blank;
    bit                   cr_held;
    bit                   cred_ok;
    bit                   header_found;
    bit                   header_ok;
    bit                   verdict_given;
    verdict_t             verdicts_due[$];
    int                   mismatches;
    int                   verdicts_seen;

    function new();
      auth_text     = "Authorization";
      cred_len      = CRED_LEN_RST;
      cred_bytes    = '0;
      mismatches    = 0;
      verdicts_seen = 0;
      open_connection();
    endfunction

    function void clear_line();
      phase      = PH_NAME;
      name_pos   = '0;
      name_ok    = 1'b1;
      line_blank = 1'b1;
      cred_pos   = '0;
      cred_ok    = 1'b1;
    endfunction

    function void open_connection();
      clear_line();
      cr_held       = 1'b0;
      header_found  = 1'b0;
      header_ok     = 1'b0;
      verdict_given = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        CFG_CRED_LEN: cred_len = d[5:0];
        CFG_WORD_0:   cred_bytes[63:0] = d;
        CFG_WORD_1:   cred_bytes[127:64] = d;
        CFG_WORD_2:   cred_bytes[191:128] = d;
        CFG_WORD_3:   cred_bytes[255:192] = d;
        default: ;
      endcase
    endfunction

    function void match_cred(logic [7:0] b);
      if (!cred_ok) return;
      if (cred_pos < cred_len && cred_pos < MAX_CRED_BYTES &&
          b == cred_bytes[8*int'(cred_pos[4:0]) +: 8]) begin
        cred_pos++;
      end else begin
        cred_ok = 1'b0;
      end
    endfunction

    function void scan_byte(logic [7:0] b);
      line_blank = 1'b0;
      case (phase)
        PH_NAME: begin
          if (b == CH_COLON) begin
            phase = PH_LEAD;
          end else if (name_ok && name_pos < AUTH_LEN &&
                       b == auth_text[8*(12-int'(name_pos)) +: 8]) begin
            name_pos++;
          end else begin
            name_ok = 1'b0;
          end
        end
        PH_LEAD: begin
          if (b != CH_SPACE) phase = PH_SCHEME;
        end
        PH_SCHEME: begin
          if (b == CH_SPACE) phase = PH_MID;
        end
        PH_MID: begin
          if (b != CH_SPACE) begin
            phase = PH_CRED;
            match_cred(b);
          end
        end
        default: match_cred(b);
      endcase
    endfunction

    function void give_verdict();
      verdict_t v;
      v.authorized  = header_found && header_ok;
      v.header_seen = header_found;
      verdict_given = 1'b1;
      verdicts_due.push_back(v);
    endfunction

    function void close_line();
      if (line_blank) begin
        give_verdict();
        return;
      end
      if (!header_found && name_ok && name_pos == AUTH_LEN) begin
        header_found = 1'b1;
        header_ok    = cred_ok && cred_pos == cred_len;
      end
      clear_line();
    endfunction

    function void note_word(logic [1:0] op, logic [7:0] b);
      if (op == OP_START) begin
        open_connection();
        return;
      end
      if (op == OP_CLOSE) begin
        if (!verdict_given) give_verdict();
        return;
      end
      if (op != OP_DATA || verdict_given) return;
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CH_LF) begin
          close_line();
          return;
        end
        scan_byte(CH_CR);
      end
      if (b == CH_CR) cr_held = 1'b1;
      else scan_byte(b);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_verdict(logic auth, logic seen);
      verdict_t v;
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %b/%b with none pending", auth, seen));
        return;
      end
      v = verdicts_due.pop_front();
      if (auth !== v.authorized)
        report_mismatch($sformatf("authorized %b, predicted %b", auth, v.authorized));
      if (seen !== v.header_seen)
        report_mismatch($sformatf("header_seen %b, predicted %b", seen, v.header_seen));
    endtask
  endclass

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_op           = OP_START;
  logic [7:0]           in_data_byte    = 8'h00;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic                 out_authorized;
  logic                 out_header_seen;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index       = CFG_CRED_LEN;
  logic [WORD_BITS-1:0] cfg_data        = '0;

  verdict_tracker       board;
  logic [5:0]           len_now         = CRED_LEN_RST;
  logic [CRED_BITS-1:0] cred_now        = '0;
  int                   words_sent      = 0;
  int                   quiet_cycles    = 0;
  int                   stall_left      = 0;
  bit                   stall_quiet     = 1'b0;
  bit                   hold_req        = 1'b0;
  bit                   gaps_on         = 1'b1;

  http_basic_auth_header_check u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_authorized  (out_authorized),
    .out_header_seen (out_header_seen),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // receiver side: random stalls, quiet stretches, one long hold on request
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_quiet = !stall_quiet;
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!stall_quiet && $urandom_range(0, 4) == 0) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_verdict(out_authorized, out_header_seen);
      if (in_valid && !in_stall) board.note_word(in_op, in_data_byte);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_DATA, s[i]);
  endtask

  task automatic send_eol();
    send_word(OP_DATA, CH_CR);
    send_word(OP_DATA, CH_LF);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_word(OP_DATA, 8'($urandom));
  endtask

  // flaw: one byte of the credential gets a bit flipped
  task automatic send_cred(input int n, input bit flaw);
    int         bad_pos;
    logic [7:0] b;
    bad_pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      b = (i < MAX_CRED_BYTES) ? cred_now[8*i +: 8] : 8'($urandom_range(33, 126));
      if (flaw && i == bad_pos) b ^= 8'(1 << $urandom_range(0, 7));
      send_word(OP_DATA, b);
    end
  endtask

  task automatic send_auth_line();
    int r;
    int n;
    r = $urandom_range(0, 9);
    if (r <= 6) send_str("Authorization");
    else if (r == 7) send_str("authorization");
    else if (r == 8) send_str("Authoriz");
    else send_str("Authorizations");
    if ($urandom_range(0, 9) == 0) begin
      send_eol();
      return;
    end
    send_word(OP_DATA, CH_COLON);
    repeat ($urandom_range(0, 2)) send_word(OP_DATA, CH_SPACE);
    r = $urandom_range(0, 9);
    if (r <= 7) send_str("Basic");
    else if (r == 8) send_str("x");
    repeat (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2))
      send_word(OP_DATA, CH_SPACE);
    n = (len_now > MAX_CRED_BYTES) ? MAX_CRED_BYTES : int'(len_now);
    r = $urandom_range(0, 9);
    case (r)
      5: send_cred((n > 0) ? n - 1 : 0, 1'b0);
      6: send_cred(n + 1, 1'b0);
      7: send_cred(n, 1'b1);
      8: begin
        send_cred(n, 1'b0);
        send_word(OP_DATA, CH_CR);
        send_word(OP_DATA, 8'($urandom_range(32, 126)));
      end
      9: ;
      default: send_cred(n, 1'b0);
    endcase
    send_eol();
  endtask

  task automatic send_other_line();
    repeat ($urandom_range(1, 6)) send_word(OP_DATA, 8'($urandom_range(65, 122)));
    if ($urandom_range(0, 3) != 0) send_word(OP_DATA, CH_COLON);
    send_noise($urandom_range(0, 8));
    send_eol();
  endtask

  task automatic random_connection();
    int r;
    gaps_on = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 9) != 0) send_word(OP_START, 8'($urandom));
    if ($urandom_range(0, 9) == 0) send_word(OP_UNUSED, 8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) < 5) send_auth_line();
      else send_other_line();
    end
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      send_eol();
    end else if (r <= 7) begin
      send_noise($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) send_word(OP_DATA, CH_CR);
      send_word(OP_CLOSE, 8'($urandom));
    end else if (r == 8) begin
      send_word(OP_CLOSE, 8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      send_noise(1);
      send_word(OP_CLOSE, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    int          len;
    logic [63:0] words [4];
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every op, lone CR, restart, name without colon, ignored words
    send_word(OP_UNUSED, 8'hFF);
    send_word(OP_CLOSE, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_CLOSE, 8'h00);
    send_word(OP_START, 8'hFF);
    send_word(OP_DATA, 8'h00);
    send_word(OP_START, 8'h00);
    send_str("Authorization");
    send_eol();
    send_word(OP_DATA, CH_CR);
    send_word(OP_DATA, CH_COLON);
    send_word(OP_CLOSE, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_DATA, CH_CR);
    send_word(OP_DATA, CH_CR);
    send_word(OP_DATA, CH_LF);
    send_eol();

    for (int round = 0; words_sent < ITEM_TARGET; round++) begin
      if (round > 0) begin
        wait_drained();
        for (int k = 0; k < 4; k++) words[k] = {$urandom, $urandom};
        case (round % 6)
          1: len = 1;
          2: len = 0;
          3: len = MAX_CRED_BYTES;
          4: begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < 4; k++) words[k] = '1;
          end
          5: begin
            len = (round < 6) ? 63 : $urandom_range(33, 62);
            for (int k = 0; k < 4; k++) words[k] = '0;
          end
          default: len = $urandom_range(2, 31);
        endcase
        write_reg(CFG_CRED_LEN, 64'(len));
        for (int k = 0; k < 4; k++) write_reg(cfg_idx_t'(int'(CFG_WORD_0) + k), words[k]);
        cfg_valid <= 1'b0;
        len_now  = 6'(len);
        cred_now = {words[3], words[2], words[1], words[0]};
      end
      random_connection();
      if (round == 1) begin
        // long output hold while verdict-producing words keep coming
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (12) begin
          send_word(OP_START, 8'($urandom));
          send_word(OP_CLOSE, 8'($urandom));
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
